// ----- rtl/core/sgm_pca_pkg.sv -----
package sgm_pca_pkg;

    // Sizes of the cost store and of the stream fields.
    localparam int DISPARITY_SLOTS = 64;
    localparam int COST_BITS       = 12;
    localparam int AGG_BITS        = COST_BITS + 1;
    localparam int DISP_BITS       = 6;
    localparam int PENALTY_BITS    = 12;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    // Each cost bank is split into four lanes by the low disparity bits, so that the
    // three neighbouring entries d-1, d and d+1 always sit in different lanes.
    localparam int SLOT_BITS = (DISPARITY_SLOTS > 1) ? $clog2(DISPARITY_SLOTS) : 1;
    localparam int BANKS     = 2;
    localparam int LANES     = 4;
    localparam int LANE_BITS = 2;
    localparam int ROWS      = (DISPARITY_SLOTS + LANES - 1) / LANES;
    localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1;

    // Index arithmetic and penalty sums get a little headroom.
    localparam int WIN_BITS = ((DISP_BITS > SLOT_BITS) ? DISP_BITS : SLOT_BITS) + 1;
    localparam int SUM_BITS = ((AGG_BITS > PENALTY_BITS) ? AGG_BITS : PENALTY_BITS) + 2;

    // Stream bus widths, padded to whole bytes.
    localparam int S_TDATA_BITS = ((COST_BITS + DISP_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((AGG_BITS + DISP_BITS + 7) / 8) * 8;

    typedef logic [COST_BITS-1:0]      cost_t;
    typedef logic [AGG_BITS-1:0]       agg_t;
    typedef logic [DISP_BITS-1:0]      disp_t;
    typedef logic [PENALTY_BITS-1:0]   penalty_t;
    typedef logic [SLOT_BITS-1:0]      slot_t;
    typedef logic [LANE_BITS-1:0]      lane_t;
    typedef logic [ROW_BITS-1:0]       row_t;
    typedef logic [WIN_BITS-1:0]       win_t;
    typedef logic [SUM_BITS-1:0]       wide_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

    localparam agg_t AGG_MAX = '1;

    // Register indexes.
    localparam cfg_index_t CFG_MAX_DISPARITY = CFG_INDEX_BITS'(0);
    localparam cfg_index_t CFG_SMALL_PENALTY = CFG_INDEX_BITS'(1);
    localparam cfg_index_t CFG_LARGE_PENALTY = CFG_INDEX_BITS'(2);

    // Register values after reset.
    localparam disp_t    RESET_MAX_DISPARITY = DISP_BITS'(63);
    localparam penalty_t RESET_SMALL_PENALTY = PENALTY_BITS'(8);
    localparam penalty_t RESET_LARGE_PENALTY = PENALTY_BITS'(32);

endpackage

// ----- rtl/core/sgm_path_cost_aggregation_unit.sv -----
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  s_tdata: match_cost, disparity; s_tuser: new_line
// m_        out        m_tvalid / m_tready  m_tdata: aggregated_cost, cost_disparity;
//                                           m_tlast: pixel_done
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A request is held in the input register and its result in the output register: the
// previous pixel's costs are read from the lane memories at the accepting edge itself, and the
// aggregation arithmetic runs from the input register into the output register.
// A new request is accepted every cycle while the output is not stalled; the rate is set
// by the single write port of each cost lane, which takes one aggregated cost per cycle.
// Reset is synchronous and active low; it needs no clearing pass, since a single flag makes
// the previous costs read as zero until the first pixel has completed.
// A stalled result holds in the output register, and the input stage then holds its request
// and drops s_tready until the result has gone.
module sgm_path_cost_aggregation_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // From bit 0: match_cost, disparity, zero padding.
    input  logic [sgm_pca_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // new_line.
    input  logic                                   s_tuser,

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // From bit 0: aggregated_cost, cost_disparity, zero padding.
    output logic [sgm_pca_pkg::M_TDATA_BITS-1:0]   m_tdata,
    output logic                                   m_tlast,

    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [sgm_pca_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sgm_pca_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import sgm_pca_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the user only
    // writes them between pixels, while the pipeline is empty.
    // ------------------------------------------------------------------
    disp_t    max_disparity_reg;
    penalty_t small_penalty_reg;
    penalty_t large_penalty_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_disparity_reg <= RESET_MAX_DISPARITY;
            small_penalty_reg <= RESET_SMALL_PENALTY;
            large_penalty_reg <= RESET_LARGE_PENALTY;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MAX_DISPARITY: max_disparity_reg <= cfg_data[DISP_BITS-1:0];
                CFG_SMALL_PENALTY: small_penalty_reg <= cfg_data[PENALTY_BITS-1:0];
                CFG_LARGE_PENALTY: large_penalty_reg <= cfg_data[PENALTY_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The highest disparity in use can never exceed the store.
    win_t emax;

    always_comb begin
        if (WIN_BITS'(max_disparity_reg) > WIN_BITS'(DISPARITY_SLOTS - 1)) begin
            emax = WIN_BITS'(DISPARITY_SLOTS - 1);
        end else begin
            emax = WIN_BITS'(max_disparity_reg);
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input stage moves on whenever the output register is
    // free or is being emptied in the same cycle.
    // ------------------------------------------------------------------
    logic  stage_valid_reg;
    cost_t stage_cost_reg;
    disp_t stage_disp_reg;
    logic  stage_fresh_reg;

    logic  out_valid_reg;
    logic  out_last_reg;
    logic [M_TDATA_BITS-1:0] out_data_reg;

    logic  advance;
    logic  s_accept;

    assign advance  = stage_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stage_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_accept) begin
            stage_valid_reg <= 1'b1;
        end else if (advance) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_cost_reg  <= s_tdata[COST_BITS-1:0];
            stage_disp_reg  <= s_tdata[COST_BITS +: DISP_BITS];
            stage_fresh_reg <= s_tuser;
        end
    end

    // ------------------------------------------------------------------
    // Read addresses. For each lane, pick the one of d-1, d and d+1 that
    // falls into it; the fourth lane reads a neighbour that is not used.
    // ------------------------------------------------------------------
    win_t in_win;
    row_t rd_row [LANES];

    assign in_win = WIN_BITS'(s_tdata[COST_BITS +: DISP_BITS]);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            lane_t off;
            win_t  addr;
            off = LANE_BITS'(l) - in_win[LANE_BITS-1:0];
            if (off == LANE_BITS'(LANES - 1)) begin
                addr = in_win - WIN_BITS'(1);
            end else begin
                addr = in_win + WIN_BITS'(off);
            end
            rd_row[l] = ROW_BITS'(addr >> LANE_BITS);
        end
    end

    // ------------------------------------------------------------------
    // Cost banks. Two banks of four lanes each. For every slot, s_bank
    // says which bank holds the previous pixel's cost and c_bank which
    // holds the current one; a new cost always goes to the bank that the
    // previous pixel does not occupy, so the swap at the end of a pixel is
    // just a copy of c_bank into s_bank. A read that meets a write to the
    // same entry in the same cycle returns the new data.
    // ------------------------------------------------------------------
    agg_t  bank_mem    [BANKS][LANES][ROWS];
    agg_t  rd_data_reg [BANKS][LANES];

    logic  wr_en;
    logic  wr_bank;
    lane_t wr_lane;
    row_t  wr_row;
    agg_t  wr_data;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (wr_en && (wr_bank == 1'(b)) && (wr_lane == LANE_BITS'(l))) begin
                    bank_mem[b][l][wr_row] <= wr_data;
                end
                if (s_accept) begin
                    if (wr_en && (wr_bank == 1'(b)) && (wr_lane == LANE_BITS'(l))
                            && (wr_row == rd_row[l])) begin
                        rd_data_reg[b][l] <= wr_data;
                    end else begin
                        rd_data_reg[b][l] <= bank_mem[b][l][rd_row[l]];
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Path state.
    // ------------------------------------------------------------------
    logic [DISPARITY_SLOTS-1:0] s_bank_reg, s_bank_next;
    logic [DISPARITY_SLOTS-1:0] c_bank_reg, c_bank_next;
    agg_t prev_minimum_reg, prev_minimum_next;
    agg_t cur_minimum_reg,  cur_minimum_next;
    logic prev_zero_reg,    prev_zero_next;

    // ------------------------------------------------------------------
    // Aggregation for the request held in the input stage.
    // ------------------------------------------------------------------
    logic in_range;
    logic is_last;
    logic stage_done;
    agg_t agg;
    agg_t result_cost;
    slot_t sd;

    always_comb begin : p_aggregate
        win_t  d_win, dm_win, dp_win;
        slot_t sm, sp;
        logic  zero;
        agg_t  raw_mid, raw_lo, raw_hi, pm, cmin;
        wide_t p_mid, p_lo, p_hi, cand_lo, cand_hi, thr, best, sum, agg_wide;

        d_win  = WIN_BITS'(stage_disp_reg);
        dm_win = d_win - WIN_BITS'(1);
        dp_win = d_win + WIN_BITS'(1);
        sd     = SLOT_BITS'(d_win);
        sm     = SLOT_BITS'(dm_win);
        sp     = SLOT_BITS'(dp_win);

        in_range   = (d_win <= emax);
        is_last    = (d_win == emax);
        stage_done = in_range && is_last;

        raw_mid = rd_data_reg[s_bank_reg[sd]][d_win[LANE_BITS-1:0]];
        raw_lo  = rd_data_reg[s_bank_reg[sm]][dm_win[LANE_BITS-1:0]];
        raw_hi  = rd_data_reg[s_bank_reg[sp]][dp_win[LANE_BITS-1:0]];

        // A new line, or a path that has not yet finished one pixel, sees zero costs.
        zero  = stage_fresh_reg || prev_zero_reg;
        p_mid = zero ? '0 : SUM_BITS'(raw_mid);
        p_lo  = zero ? '0 : SUM_BITS'(raw_lo);
        p_hi  = zero ? '0 : SUM_BITS'(raw_hi);
        pm    = stage_fresh_reg ? '0 : prev_minimum_reg;

        cand_lo = p_lo + SUM_BITS'(small_penalty_reg);
        cand_hi = p_hi + SUM_BITS'(small_penalty_reg);
        thr     = SUM_BITS'(pm) + SUM_BITS'(large_penalty_reg);

        best = p_mid;
        if ((d_win != '0) && (cand_lo < best)) begin
            best = cand_lo;
        end
        if ((d_win < emax) && (cand_hi < best)) begin
            best = cand_hi;
        end
        if (thr < best) begin
            best = thr;
        end

        // Subtracting the previous minimum keeps the costs bounded; a sum that
        // falls below it clamps at zero and a large one saturates.
        sum      = SUM_BITS'(stage_cost_reg) + best;
        agg_wide = (sum >= SUM_BITS'(pm)) ? (sum - SUM_BITS'(pm)) : '0;
        agg      = (agg_wide > SUM_BITS'(AGG_MAX)) ? AGG_MAX : agg_wide[AGG_BITS-1:0];

        // Requests beyond the highest disparity leave all state untouched.
        result_cost = in_range ? agg : '0;

        wr_en   = advance && in_range;
        wr_bank = ~s_bank_reg[sd];
        wr_lane = d_win[LANE_BITS-1:0];
        wr_row  = ROW_BITS'(d_win >> LANE_BITS);
        wr_data = agg;

        cmin = (agg < cur_minimum_reg) ? agg : cur_minimum_reg;

        s_bank_next       = s_bank_reg;
        c_bank_next       = c_bank_reg;
        prev_minimum_next = prev_minimum_reg;
        cur_minimum_next  = cur_minimum_reg;
        prev_zero_next    = prev_zero_reg;
        if (wr_en) begin
            c_bank_next[sd] = wr_bank;
            if (is_last) begin
                // End of pixel: the current costs become the previous ones.
                s_bank_next       = c_bank_next;
                prev_minimum_next = cmin;
                cur_minimum_next  = AGG_MAX;
                prev_zero_next    = 1'b0;
            end else begin
                cur_minimum_next = cmin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_bank_reg       <= '0;
            c_bank_reg       <= '0;
            prev_minimum_reg <= '0;
            cur_minimum_reg  <= AGG_MAX;
            prev_zero_reg    <= 1'b1;
        end else begin
            s_bank_reg       <= s_bank_next;
            c_bank_reg       <= c_bank_next;
            prev_minimum_reg <= prev_minimum_next;
            cur_minimum_reg  <= cur_minimum_next;
            prev_zero_reg    <= prev_zero_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= M_TDATA_BITS'({stage_disp_reg, result_cost});
            out_last_reg <= stage_done;
        end
    end

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_hold_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while both stages are blocked");

    a_swap_banks: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stage_done) |=> (s_bank_reg == c_bank_reg))
        else $error("bank maps differ after the end of a pixel");

    a_min_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && stage_done) |=> ((cur_minimum_reg == AGG_MAX) && !prev_zero_reg))
        else $error("running minimum not restarted after the end of a pixel");

    a_out_of_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !in_range) |=> ((out_data_reg[AGG_BITS-1:0] == '0) && !out_last_reg))
        else $error("out-of-range disparity gave a non-zero cost or a pixel end");

endmodule

// ----- tb/path_cost_tracker_pkg.sv -----
package path_cost_tracker_pkg;

    import sgm_pca_pkg::*;

    // One aggregated cost as it should leave the block.
    typedef struct {
        agg_t  cost;
        disp_t disp;
        logic  done;
    } aggregated_item_t;

    // Keeps its own copy of the two cost banks and the registers, works out the aggregated
    // cost of every accepted request and holds it until the block's result arrives.
    class path_cost_tracker;

        agg_t             prev_bank [DISPARITY_SLOTS];
        agg_t             cur_bank  [DISPARITY_SLOTS];
        agg_t             prev_min;
        agg_t             cur_min;
        disp_t            top_disp;
        penalty_t         step_pen;
        penalty_t         jump_pen;
        aggregated_item_t awaited_costs [$];
        int unsigned      mismatches;
        int unsigned      matched;

        function new();
            foreach (prev_bank[i]) begin
                prev_bank[i] = '0;
                cur_bank[i]  = '0;
            end
            prev_min    = '0;
            cur_min     = AGG_MAX;
            top_disp    = RESET_MAX_DISPARITY;
            step_pen    = RESET_SMALL_PENALTY;
            jump_pen    = RESET_LARGE_PENALTY;
            mismatches  = 0;
            matched     = 0;
        endfunction

        function void set_register(cfg_index_t idx, cfg_data_t value);
            case (idx)
                CFG_MAX_DISPARITY: top_disp = value[DISP_BITS-1:0];
                CFG_SMALL_PENALTY: step_pen = value[PENALTY_BITS-1:0];
                CFG_LARGE_PENALTY: jump_pen = value[PENALTY_BITS-1:0];
                default: ;
            endcase
        endfunction

        // A new scan line reads the previous pixel as all zero.
        function int unsigned prev_cost(int unsigned idx, logic fresh);
            if (fresh || idx >= DISPARITY_SLOTS)
                return 0;
            return prev_bank[idx];
        endfunction

        // Returns 1 when the disparity lies within the current pixel size.
        function bit predict_cost(cost_t c, disp_t d, logic fresh);
            int unsigned      top;
            int unsigned      base;
            int unsigned      best;
            int unsigned      cand;
            int unsigned      total;
            int unsigned      agg;
            aggregated_item_t item;
            top = (top_disp > DISPARITY_SLOTS - 1) ? DISPARITY_SLOTS - 1 : top_disp;
            item.disp = d;
            item.done = 1'b0;
            if (d > top) begin
                // Out-of-range disparity: reported as zero, nothing stored.
                item.cost = '0;
                awaited_costs.push_back(item);
                return 1'b0;
            end
            base = fresh ? 0 : prev_min;
            best = prev_cost(d, fresh);
            if (d > 0) begin
                cand = prev_cost(d - 1, fresh) + step_pen;
                if (cand < best)
                    best = cand;
            end
            if (d < top) begin
                cand = prev_cost(d + 1, fresh) + step_pen;
                if (cand < best)
                    best = cand;
            end
            cand = base + jump_pen;
            if (cand < best)
                best = cand;
            total = c + best;
            agg = (total >= base) ? total - base : 0;
            if (agg > AGG_MAX)
                agg = AGG_MAX;
            cur_bank[d] = agg_t'(agg);
            if (agg_t'(agg) < cur_min)
                cur_min = agg_t'(agg);
            if (d == top) begin
                prev_bank = cur_bank;
                prev_min  = cur_min;
                cur_min   = AGG_MAX;
                item.done = 1'b1;
            end
            item.cost = agg_t'(agg);
            awaited_costs.push_back(item);
            return 1'b1;
        endfunction

        function void compare_cost(agg_t cost, disp_t disp, logic done);
            aggregated_item_t want;
            if (awaited_costs.size() == 0) begin
                $error("result with no request waiting: aggregated_cost %0d, cost_disparity %0d",
                       cost, disp);
                mismatches++;
                return;
            end
            want = awaited_costs.pop_front();
            matched++;
            if (cost !== want.cost) begin
                $error("aggregated_cost: expected %0d, actual %0d", want.cost, cost);
                mismatches++;
            end
            if (disp !== want.disp) begin
                $error("cost_disparity: expected %0d, actual %0d", want.disp, disp);
                mismatches++;
            end
            if (done !== want.done) begin
                $error("pixel_done: expected %0d, actual %0d", want.done, done);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return awaited_costs.size();
        endfunction

    endclass

endpackage

// ----- tb/tb.sv -----
module tb;

    import sgm_pca_pkg::*;
    import path_cost_tracker_pkg::*;

    // Index 3 names no register; a write to it must leave every setting alone.
    localparam cfg_index_t CFG_SPARE_INDEX = CFG_INDEX_BITS'(3);

    // Cycles without any accepted request before the run is declared hung. The slowest
    // legitimate wait is a long sender gap on top of a long receiver stall, well under this.
    localparam int STALL_LIMIT   = 2000;
    localparam int COST_TARGET   = 900;
    // The block passes each request through its input register and then its output register;
    // the settling wait covers any slack.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata;
    logic                    s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    cfg_index_t              cfg_index;
    cfg_data_t               cfg_data;

    path_cost_tracker tracker;

    // When set, the sender offers requests back to back.
    bit          steady;
    int unsigned in_range_costs;
    int unsigned stray_costs;
    int unsigned settings_used;
    int unsigned widest_pixels;

    sgm_path_cost_aggregation_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Mostly no gap or a short one, now and then a long pause.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Small costs make the neighbour and jump terms compete; the extremes are kept in play.
    function automatic cost_t pick_cost();
        case ($urandom_range(0, 3))
            0: return cost_t'($urandom_range(0, 31));
            1: return $urandom_range(0, 1) ? '1 : '0;
            default: return cost_t'($urandom());
        endcase
    endfunction

    // Offers one cost request and returns once the block has taken it. Handshake signals
    // are sampled at the clock edge, so the values seen are those from before the edge.
    task automatic send_cost(cost_t c, disp_t d, logic fresh);
        int unsigned gap;
        gap = steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'({d, c});
        s_tuser  <= fresh;
        do @(posedge aclk); while (!s_tready);
        if (tracker.predict_cost(c, d, fresh))
            in_range_costs++;
        else
            stray_costs++;
    endtask

    // Sends the disparities first to last in order, with the new-line flag when asked and rarely at random.
    task automatic send_run(int unsigned first, int unsigned last, logic fresh);
        int unsigned d;
        for (d = first; d <= last; d++)
            send_cost(pick_cost(), disp_t'(d), fresh || ($urandom_range(0, 39) == 0));
    endtask

    // cfg_valid is left high so that writes can follow one another; the caller lowers it.
    task automatic write_register(cfg_index_t idx, cfg_data_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_register(idx, value);
    endtask

    // Stops sending and waits until every awaited result has been taken, so the block is
    // idle before the registers change.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Every result the block hands over is compared with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.compare_cost(m_tdata[AGG_BITS-1:0], m_tdata[AGG_BITS +: DISP_BITS], m_tlast);
    end

    // The receiver: short bursts with brief stalls, some long stretches of steady readiness
    // and the occasional long stall that backs the whole pipeline up.
    initial begin
        int unsigned mode;
        m_tready <= 1'b0;
        wait (aresetn);
        forever begin
            mode = $urandom_range(0, 9);
            if (mode < 2) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge aclk);
            end else if (mode < 9) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            end
        end
    end

    // Watchdog: any channel moving a request counts as progress.
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        int unsigned top;
        int unsigned last_top;
        int unsigned pixels;
        int unsigned p;
        int unsigned kind;
        int unsigned d;
        int unsigned i;
        int unsigned j;
        int unsigned n;
        int unsigned tmp;
        int unsigned order [DISPARITY_SLOTS];
        logic        fresh;
        logic        fresh_first;
        cfg_data_t   value;

        tracker        = new();
        steady         = 1'b0;
        in_range_costs = 0;
        stray_costs    = 0;
        settings_used  = 0;
        widest_pixels  = 0;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_MAX_DISPARITY;
        cfg_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Four costs per pixel, a huge step penalty and no jump penalty.
        write_register(CFG_MAX_DISPARITY, cfg_data_t'(3));
        write_register(CFG_SMALL_PENALTY, '1);
        write_register(CFG_LARGE_PENALTY, '0);
        cfg_valid <= 1'b0;
        settings_used++;
        // Straight after reset the previous pixel reads as zero; extreme costs alternate.
        send_cost('0, disp_t'(0), 1'b0);
        send_cost('1, disp_t'(1), 1'b0);
        send_cost('0, disp_t'(2), 1'b0);
        send_cost('1, disp_t'(3), 1'b0);
        // Largest cost everywhere, built on a real previous pixel.
        for (d = 0; d <= 3; d++)
            send_cost('1, disp_t'(d), 1'b0);
        // Disparities beyond the pixel size are reported as zero and change nothing.
        send_cost('1, disp_t'(DISPARITY_SLOTS - 1), 1'b1);
        send_cost('0, disp_t'(4), 1'b0);
        // A whole pixel flagged as the start of a new scan line.
        send_cost('0, disp_t'(0), 1'b1);
        send_cost('1, disp_t'(1), 1'b1);
        send_cost(cost_t'(1), disp_t'(2), 1'b1);
        send_cost(cost_t'(2048), disp_t'(3), 1'b1);
        // The new-line flag on one item only.
        send_cost(cost_t'(7), disp_t'(0), 1'b0);
        send_cost(cost_t'(100), disp_t'(1), 1'b1);
        send_cost(cost_t'(5), disp_t'(2), 1'b0);
        send_cost('0, disp_t'(3), 1'b0);
        drain();

        // A single cost per pixel: the upper data bits of the size write fall away, leaving
        // zero. The spare index is written with all ones and must have no effect.
        write_register(CFG_MAX_DISPARITY, cfg_data_t'(DISPARITY_SLOTS));
        write_register(CFG_SMALL_PENALTY, '0);
        write_register(CFG_LARGE_PENALTY, '1);
        write_register(CFG_SPARE_INDEX, '1);
        cfg_valid <= 1'b0;
        settings_used++;
        send_cost('1, disp_t'(0), 1'b0);
        send_cost('0, disp_t'(0), 1'b0);
        send_cost(cost_t'(12), disp_t'(0), 1'b1);
        send_cost(cost_t'(1), disp_t'(1), 1'b0);
        last_top = 0;

        // Random part: a run of register settings, each followed by a few pixels. Every
        // setting starts from an idle block, which also makes the sender wait for all
        // outstanding results.
        while (in_range_costs < COST_TARGET) begin
            drain();
            case ($urandom_range(0, 9))
                0: top = 0;
                1: top = DISPARITY_SLOTS - 1;
                2: top = $urandom_range(8, DISPARITY_SLOTS - 2);
                default: top = $urandom_range(1, 7);
            endcase
            value = cfg_data_t'(top);
            if ($urandom_range(0, 1) == 1)
                value = value | cfg_data_t'($urandom_range(0, 63) << DISP_BITS);
            write_register(CFG_MAX_DISPARITY, value);
            case ($urandom_range(0, 4))
                0: value = '0;
                1: value = '1;
                2, 3: value = cfg_data_t'($urandom_range(0, 15));
                default: value = cfg_data_t'($urandom());
            endcase
            write_register(CFG_SMALL_PENALTY, value);
            case ($urandom_range(0, 4))
                0: value = '0;
                1: value = '1;
                2, 3: value = cfg_data_t'($urandom_range(16, 255));
                default: value = cfg_data_t'($urandom());
            endcase
            write_register(CFG_LARGE_PENALTY, value);
            if ($urandom_range(0, 9) == 0)
                write_register(CFG_SPARE_INDEX, cfg_data_t'($urandom()));
            cfg_valid <= 1'b0;
            settings_used++;

            // When the pixel grows, the previous bank holds nothing valid above the old
            // size, so the first pixel starts a new scan line.
            fresh_first = (top > last_top);
            last_top    = top;
            pixels      = (top >= 32) ? $urandom_range(1, 2) : $urandom_range(2, 6);
            if (top == DISPARITY_SLOTS - 1)
                widest_pixels += pixels;

            for (p = 0; p < pixels; p++) begin
                steady = ($urandom_range(0, 4) == 0);
                fresh  = (fresh_first && p == 0) || ($urandom_range(0, 9) == 0);
                kind   = $urandom_range(0, 99);
                if (kind >= 72 && kind < 80 && top < DISPARITY_SLOTS - 1) begin
                    // Stray disparities beyond the pixel size between the real ones.
                    for (d = 0; d <= top; d++) begin
                        if ($urandom_range(0, 2) == 0)
                            send_cost(pick_cost(),
                                      disp_t'($urandom_range(top + 1, DISPARITY_SLOTS - 1)),
                                      1'($urandom_range(0, 1)));
                        send_cost(pick_cost(), disp_t'(d), fresh);
                    end
                end else if (kind >= 80 && kind < 87 && top > 0) begin
                    // Some disparities are sent twice; the last one never is, since that
                    // would close a pixel whose other costs are unwritten.
                    for (d = 0; d <= top; d++) begin
                        send_cost(pick_cost(), disp_t'(d), fresh);
                        if (d < top && $urandom_range(0, 3) == 0)
                            send_cost(pick_cost(), disp_t'(d), fresh);
                    end
                end else if (kind >= 87 && kind < 94 && top > 1) begin
                    // All but the last disparity in shuffled order, then the last.
                    n = top;
                    for (i = 0; i < n; i++)
                        order[i] = i;
                    for (i = n - 1; i >= 1; i--) begin
                        j        = $urandom_range(0, i);
                        tmp      = order[i];
                        order[i] = order[j];
                        order[j] = tmp;
                    end
                    for (i = 0; i < n; i++)
                        send_cost(pick_cost(), disp_t'(order[i]), fresh);
                    send_cost(pick_cost(), disp_t'(top), fresh);
                end else if (kind >= 94 && top > 0) begin
                    // A pixel broken off part-way and started again from zero.
                    send_run(0, $urandom_range(0, top - 1), fresh);
                    send_run(0, top, fresh);
                end else begin
                    send_run(0, top, fresh);
                end
            end
        end
        steady = 1'b0;

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d in-range and %0d out-of-range costs over %0d register settings",
                 in_range_costs, stray_costs, settings_used);
        $display("tb: %0d results compared, %0d pixels at the widest size",
                 tracker.matched, widest_pixels);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/sgm_pca_pkg.sv
rtl/core/sgm_path_cost_aggregation_unit.sv
tb/path_cost_tracker_pkg.sv
tb/tb.sv
